// ===== rtl/rsbm_pkg.sv =====
// ----------------------------------------------------------------------------
// rsbm_pkg
// Shared constants, register codes and types of the rotozoom blit mapper.
// ----------------------------------------------------------------------------
package rsbm_pkg;

   // Image limits and fixed point format
   localparam int SRC_MAX_DIM  = 256;
   localparam int DEST_MAX_DIM = 1024;
   localparam int FRAC_BITS    = 12;

   localparam int SRC_COORD_W = $clog2(SRC_MAX_DIM);
   localparam int SRC_AW      = 2 * SRC_COORD_W;
   localparam int SRC_WORDS   = SRC_MAX_DIM * SRC_MAX_DIM;

   // Field widths
   localparam int SRC_SIZE_W  = 9;
   localparam int DEST_SIZE_W = 11;
   localparam int POS_W       = 11;
   localparam int COEF_W      = 16;
   localparam int COLOR_W     = 32;
   localparam int INDEX_W     = 16;
   localparam int OUT_W       = 10;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 16;

   // Arithmetic widths
   localparam int PROD_W = POS_W + COEF_W;
   localparam int SUM_W  = PROD_W + 1;
   localparam int T_W    = SUM_W + 2;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SOURCE_WIDTH  = 3'd0,
      CSR_SOURCE_HEIGHT = 3'd1,
      CSR_DEST_WIDTH    = 3'd2,
      CSR_DEST_HEIGHT   = 3'd3,
      CSR_INSERT_X      = 3'd4,
      CSR_INSERT_Y      = 3'd5,
      CSR_COEF_COS      = 3'd6,
      CSR_COEF_SIN      = 3'd7
   } csr_index_type;

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_MAP  = 1'b1;

   typedef struct packed {
      logic [SRC_SIZE_W-1:0]  source_width;
      logic [SRC_SIZE_W-1:0]  source_height;
      logic [DEST_SIZE_W-1:0] dest_width;
      logic [DEST_SIZE_W-1:0] dest_height;
      logic signed [POS_W-1:0]  insert_x;
      logic signed [POS_W-1:0]  insert_y;
      logic signed [COEF_W-1:0] coef_cos;
      logic signed [COEF_W-1:0] coef_sin;
   } cfg_type;

   // Memory access issued by the coordinate transform
   typedef struct packed {
      logic               valid;
      logic               is_map;
      logic               hit;
      logic               write;
      logic [SRC_AW-1:0]  addr;
      logic [COLOR_W-1:0] wdata;
      logic [OUT_W-1:0]   dx;
      logic [OUT_W-1:0]   dy;
   } access_type;

endpackage

// ===== rtl/rotate_scale_blit_mapper_top.sv =====
// ----------------------------------------------------------------------------
// rotate_scale_blit_mapper_top
// Rotozoom blit by inverse mapping with nearest neighbour sampling from a
// source image held in a single port RAM.
// A request passes the stage 1, stage 2, RAM read and stage 3, and output
// registers. Throughput: one transaction per cycle unless the output is held;
// each item makes one access to the source RAM port, which sets the rate.
// Reset: synchronous; empties the pipeline and restores register defaults.
// Source RAM contents are not cleared and read as undefined until loaded.
// ----------------------------------------------------------------------------
module rotate_scale_blit_mapper_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_opcode,
   input  logic [rsbm_pkg::INDEX_W-1:0]        req_load_index,
   input  logic [rsbm_pkg::COLOR_W-1:0]        req_load_color,
   input  logic signed [rsbm_pkg::POS_W-1:0]   req_offset_x,
   input  logic signed [rsbm_pkg::POS_W-1:0]   req_offset_y,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_write_enable,
   output logic [rsbm_pkg::OUT_W-1:0]          rsp_out_x,
   output logic [rsbm_pkg::OUT_W-1:0]          rsp_out_y,
   output logic [rsbm_pkg::COLOR_W-1:0]        rsp_out_color,
   input  logic                                csr_write_enable,
   input  logic [rsbm_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [rsbm_pkg::CSR_DATA_W-1:0]     csr_write_data
);

   // ---- configuration registers
   rsbm_pkg::cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (rsbm_pkg::csr_index_type'(csr_index))
            rsbm_pkg::CSR_SOURCE_WIDTH:
               cfg_in.source_width  = csr_write_data[rsbm_pkg::SRC_SIZE_W-1:0];
            rsbm_pkg::CSR_SOURCE_HEIGHT:
               cfg_in.source_height = csr_write_data[rsbm_pkg::SRC_SIZE_W-1:0];
            rsbm_pkg::CSR_DEST_WIDTH:
               cfg_in.dest_width    = csr_write_data[rsbm_pkg::DEST_SIZE_W-1:0];
            rsbm_pkg::CSR_DEST_HEIGHT:
               cfg_in.dest_height   = csr_write_data[rsbm_pkg::DEST_SIZE_W-1:0];
            rsbm_pkg::CSR_INSERT_X:
               cfg_in.insert_x = $signed(csr_write_data[rsbm_pkg::POS_W-1:0]);
            rsbm_pkg::CSR_INSERT_Y:
               cfg_in.insert_y = $signed(csr_write_data[rsbm_pkg::POS_W-1:0]);
            rsbm_pkg::CSR_COEF_COS:
               cfg_in.coef_cos = $signed(csr_write_data[rsbm_pkg::COEF_W-1:0]);
            rsbm_pkg::CSR_COEF_SIN:
               cfg_in.coef_sin = $signed(csr_write_data[rsbm_pkg::COEF_W-1:0]);
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.source_width  <= rsbm_pkg::SRC_SIZE_W'(rsbm_pkg::SRC_MAX_DIM);
         cfg_ff.source_height <= rsbm_pkg::SRC_SIZE_W'(rsbm_pkg::SRC_MAX_DIM);
         cfg_ff.dest_width    <= rsbm_pkg::DEST_SIZE_W'(rsbm_pkg::DEST_MAX_DIM);
         cfg_ff.dest_height   <= rsbm_pkg::DEST_SIZE_W'(rsbm_pkg::DEST_MAX_DIM);
         cfg_ff.insert_x      <= '0;
         cfg_ff.insert_y      <= '0;
         cfg_ff.coef_cos      <= rsbm_pkg::COEF_W'(1) <<< rsbm_pkg::FRAC_BITS;
         cfg_ff.coef_sin      <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // ---- pipeline advance: the whole pipe moves when the output register frees
   logic advance;
   logic rsp_valid_ff;

   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = advance;

   rsbm_pkg::access_type acc;

   rsbm_xform u_xform (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .in_valid    (req_valid),
      .in_opcode   (req_opcode),
      .in_index    (req_load_index),
      .in_color    (req_load_color),
      .in_offset_x (req_offset_x),
      .in_offset_y (req_offset_y),
      .cfg         (cfg_ff),
      .acc         (acc)
   );

   // ---- source image memory: loads and map reads share the one port in order
   logic [rsbm_pkg::COLOR_W-1:0] ram_rdata;

   rsbm_ram #(
      .WIDTH (rsbm_pkg::COLOR_W),
      .DEPTH (rsbm_pkg::SRC_WORDS)
   ) u_source_ram (
      .clock (clock),
      .en    (advance && acc.valid),
      .we    (acc.write),
      .addr  (acc.addr),
      .wdata (acc.wdata),
      .rdata (ram_rdata)
   );

   // ---- stage 3: wait for read data
   logic                       s3_valid_ff, s3_map_ff, s3_hit_ff;
   logic [rsbm_pkg::OUT_W-1:0] s3_dx_ff, s3_dy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (advance) begin
         s3_valid_ff <= acc.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s3_map_ff <= acc.is_map;
         s3_hit_ff <= acc.hit;
         s3_dx_ff  <= acc.dx;
         s3_dy_ff  <= acc.dy;
      end
   end

   // ---- output register; transparent colour drops the write
   logic                         write_in;
   logic                         rsp_we_ff;
   logic [rsbm_pkg::OUT_W-1:0]   rsp_x_ff, rsp_y_ff;
   logic [rsbm_pkg::COLOR_W-1:0] rsp_color_ff;

   assign write_in = s3_map_ff && s3_hit_ff && (ram_rdata != '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_we_ff    <= write_in;
         rsp_x_ff     <= write_in ? s3_dx_ff  : '0;
         rsp_y_ff     <= write_in ? s3_dy_ff  : '0;
         rsp_color_ff <= write_in ? ram_rdata : '0;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_write_enable = rsp_we_ff;
   assign rsp_out_x        = rsp_x_ff;
   assign rsp_out_y        = rsp_y_ff;
   assign rsp_out_color    = rsp_color_ff;

   // ---- assertions
   a_no_write_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_write_enable |->
         rsp_out_x == '0 && rsp_out_y == '0 && rsp_out_color == '0)
      else $error("result without write carries non-zero fields");

   a_write_opaque : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_write_enable |-> rsp_out_color != '0)
      else $error("write issued with transparent colour");

   a_load_no_write : assert property (@(posedge clock) disable iff (reset)
      advance && s3_valid_ff && !s3_map_ff |=> rsp_valid && !rsp_write_enable)
      else $error("load transaction produced a write");

   a_stage_drains : assert property (@(posedge clock) disable iff (reset)
      advance && s3_valid_ff |=> rsp_valid)
      else $error("transaction lost between read stage and output");

endmodule

// ===== rtl/rsbm_ram.sv =====
// ----------------------------------------------------------------------------
// rsbm_ram
// Single port synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module rsbm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     en,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            mem_ff[addr] <= wdata;
         end
         rdata_ff <= mem_ff[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/rsbm_xform.sv =====
// ----------------------------------------------------------------------------
// rsbm_xform
// Two stage inverse mapping: destination bounds and products, projections,
// then source coordinate, source bounds and memory address.
// ----------------------------------------------------------------------------
module rsbm_xform (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            advance,
   input  logic                            in_valid,
   input  logic                            in_opcode,
   input  logic [rsbm_pkg::INDEX_W-1:0]    in_index,
   input  logic [rsbm_pkg::COLOR_W-1:0]    in_color,
   input  logic signed [rsbm_pkg::POS_W-1:0] in_offset_x,
   input  logic signed [rsbm_pkg::POS_W-1:0] in_offset_y,
   input  rsbm_pkg::cfg_type               cfg,
   output rsbm_pkg::access_type            acc
);

   localparam int TW = rsbm_pkg::T_W;
   localparam int FB = rsbm_pkg::FRAC_BITS;
   localparam int CW = rsbm_pkg::SRC_COORD_W;
   localparam int SW = rsbm_pkg::SRC_SIZE_W;
   localparam int DW = rsbm_pkg::DEST_SIZE_W;
   localparam logic signed [TW-1:0] ONE_Q  = TW'(1) << FB;
   localparam logic signed [TW-1:0] FRAC_M = ONE_Q - TW'(1);

   // Saturated dimensions
   logic [SW-1:0] sw_sat, sh_sat;
   logic [DW-1:0] dw_sat, dh_sat;

   assign sw_sat = (cfg.source_width  > SW'(rsbm_pkg::SRC_MAX_DIM)) ?
                   SW'(rsbm_pkg::SRC_MAX_DIM) : cfg.source_width;
   assign sh_sat = (cfg.source_height > SW'(rsbm_pkg::SRC_MAX_DIM)) ?
                   SW'(rsbm_pkg::SRC_MAX_DIM) : cfg.source_height;
   assign dw_sat = (cfg.dest_width    > DW'(rsbm_pkg::DEST_MAX_DIM)) ?
                   DW'(rsbm_pkg::DEST_MAX_DIM) : cfg.dest_width;
   assign dh_sat = (cfg.dest_height   > DW'(rsbm_pkg::DEST_MAX_DIM)) ?
                   DW'(rsbm_pkg::DEST_MAX_DIM) : cfg.dest_height;

   // ---- stage 1: destination check and the four products
   logic signed [rsbm_pkg::POS_W:0] dx_full, dy_full;
   logic                            dest_ok;

   assign dx_full = (rsbm_pkg::POS_W+1)'(cfg.insert_x) + (rsbm_pkg::POS_W+1)'(in_offset_x);
   assign dy_full = (rsbm_pkg::POS_W+1)'(cfg.insert_y) + (rsbm_pkg::POS_W+1)'(in_offset_y);
   assign dest_ok = !dx_full[rsbm_pkg::POS_W] && (dx_full[DW-1:0] < dw_sat) &&
                    !dy_full[rsbm_pkg::POS_W] && (dy_full[DW-1:0] < dh_sat);

   logic                                s1_valid_ff, s1_map_ff;
   logic                                s1_dest_ok_ff;
   logic [rsbm_pkg::OUT_W-1:0]          s1_dx_ff, s1_dy_ff;
   logic signed [rsbm_pkg::PROD_W-1:0]  s1_xc_ff, s1_ys_ff, s1_yc_ff, s1_xs_ff;
   logic [rsbm_pkg::INDEX_W-1:0]        s1_index_ff;
   logic [rsbm_pkg::COLOR_W-1:0]        s1_color_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_map_ff     <= (in_opcode == rsbm_pkg::OP_MAP);
         s1_dest_ok_ff <= dest_ok;
         s1_dx_ff      <= dx_full[rsbm_pkg::OUT_W-1:0];
         s1_dy_ff      <= dy_full[rsbm_pkg::OUT_W-1:0];
         s1_xc_ff      <= in_offset_x * cfg.coef_cos;
         s1_ys_ff      <= in_offset_y * cfg.coef_sin;
         s1_yc_ff      <= in_offset_y * cfg.coef_cos;
         s1_xs_ff      <= in_offset_x * cfg.coef_sin;
         s1_index_ff   <= in_index;
         s1_color_ff   <= in_color;
      end
   end

   // ---- stage 2: projections
   logic signed [rsbm_pkg::SUM_W-1:0] px_in, py_in;

   assign px_in = rsbm_pkg::SUM_W'(s1_xc_ff) + rsbm_pkg::SUM_W'(s1_ys_ff);
   assign py_in = rsbm_pkg::SUM_W'(s1_yc_ff) - rsbm_pkg::SUM_W'(s1_xs_ff);

   logic                              s2_valid_ff, s2_map_ff, s2_dest_ok_ff;
   logic [rsbm_pkg::OUT_W-1:0]        s2_dx_ff, s2_dy_ff;
   logic signed [rsbm_pkg::SUM_W-1:0] s2_px_ff, s2_py_ff;
   logic [rsbm_pkg::INDEX_W-1:0]      s2_index_ff;
   logic [rsbm_pkg::COLOR_W-1:0]      s2_color_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (advance) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s2_map_ff     <= s1_map_ff;
         s2_dest_ok_ff <= s1_dest_ok_ff;
         s2_dx_ff      <= s1_dx_ff;
         s2_dy_ff      <= s1_dy_ff;
         s2_px_ff      <= px_in;
         s2_py_ff      <= py_in;
         s2_index_ff   <= s1_index_ff;
         s2_color_ff   <= s1_color_ff;
      end
   end

   // Source centre in Q format, then subtract one for a negative projection
   // and truncate toward zero.
   logic signed [TW-1:0] cx, cy, tx, ty, tx_adj, ty_adj, sx, sy;
   logic                 src_ok, load_ok;

   assign cx = $signed({{(TW-SW-FB+1){1'b0}}, sw_sat, {(FB-1){1'b0}}});
   assign cy = $signed({{(TW-SW-FB+1){1'b0}}, sh_sat, {(FB-1){1'b0}}});
   assign tx = cx + TW'(s2_px_ff) - (s2_px_ff[rsbm_pkg::SUM_W-1] ? ONE_Q : '0);
   assign ty = cy + TW'(s2_py_ff) - (s2_py_ff[rsbm_pkg::SUM_W-1] ? ONE_Q : '0);
   assign tx_adj = tx[TW-1] ? tx + FRAC_M : tx;
   assign ty_adj = ty[TW-1] ? ty + FRAC_M : ty;
   assign sx = tx_adj >>> FB;
   assign sy = ty_adj >>> FB;

   assign src_ok = !sx[TW-1] && (sx[TW-2:0] < (TW-1)'(sw_sat)) &&
                   !sy[TW-1] && (sy[TW-2:0] < (TW-1)'(sh_sat));
   assign load_ok = 32'(s2_index_ff) < 32'(rsbm_pkg::SRC_WORDS);

   always_comb begin
      acc.valid  = s2_valid_ff;
      acc.is_map = s2_map_ff;
      acc.hit    = s2_map_ff ? (s2_dest_ok_ff && src_ok) : load_ok;
      acc.write  = !s2_map_ff && load_ok;
      acc.addr   = s2_map_ff ? {sy[CW-1:0], sx[CW-1:0]} :
                               s2_index_ff[rsbm_pkg::SRC_AW-1:0];
      acc.wdata  = s2_color_ff;
      acc.dx     = s2_dx_ff;
      acc.dy     = s2_dy_ff;
   end

endmodule
